/* rtl/tick_tone_sequencer_with_mode_button_defines.svh */
// ----------------------------------------------------------------------------
// Tick tone sequencer assertion macros
// Shared concurrent assertion forms for the tick tone sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef TICK_TONE_SEQUENCER_WITH_MODE_BUTTON_DEFINES_SVH
`define TICK_TONE_SEQUENCER_WITH_MODE_BUTTON_DEFINES_SVH

// Same-cycle implication
`define TTSMB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define TTSMB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/ttsmb_pkg.sv */
// ----------------------------------------------------------------------------
// Tick tone sequencer package
// Transaction types, command codes and the power-up tune.
// ----------------------------------------------------------------------------
`default_nettype none

package ttsmb_pkg;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_START = 2'd1,
      CMD_STOP  = 2'd2,
      CMD_WRITE = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic       button;
      logic [3:0] entry_index;
      logic [7:0] entry_value;
   } req_type;

   typedef struct packed {
      logic       tone_level;
      logic       tick_wave;
      logic [1:0] mode;
      logic       playing;
   } rsp_type;

   // Entry index is 4 bits, so at most 8 (count, half-period) rows are writable
   localparam int MAX_ROWS = 8;

   localparam logic [7:0] TUNE_DEFAULT [16] = '{
      8'd100, 8'd2, 8'd100, 8'd0, 8'd100, 8'd3, 8'd100, 8'd0,
      8'd0,   8'd0, 8'd0,   8'd0, 8'd0,   8'd0, 8'd0,   8'd0
   };

   // Power-up byte of a row: half selects the half-period byte over the count
   function automatic logic [7:0] tune_default(input logic [2:0] row, input logic half);
      return TUNE_DEFAULT[{row, half}];
   endfunction

endpackage

`default_nettype wire

/* rtl/ttsmb_ram.sv */
// ----------------------------------------------------------------------------
// Tick tone sequencer RAM
// Generic RAM, one write port and two registered read ports (read-first).
// ----------------------------------------------------------------------------
`default_nettype none

module ttsmb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd0_addr,
   output logic [WIDTH-1:0]                      rd0_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd1_addr,
   output logic [WIDTH-1:0]                      rd1_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd0_data <= mem[rd0_addr];
      rd1_data <= mem[rd1_addr];
   end

endmodule

`default_nettype wire

/* rtl/tick_tone_sequencer_with_mode_button.sv */
// ----------------------------------------------------------------------------
// Tick tone sequencer with mode button
// Results are registered on acceptance; the next tune rows are prefetched from RAM.
// Throughput: one transaction per cycle while the skid stage is empty.
// Reset (synchronous): idle, counters and levels zero, power-up tune restored.
// ----------------------------------------------------------------------------
`default_nettype none
`include "tick_tone_sequencer_with_mode_button_defines.svh"

module tick_tone_sequencer_with_mode_button
   import ttsmb_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int HALF_DEPTH = TABLE_DEPTH / 2;
   localparam int ROWS = (HALF_DEPTH < MAX_ROWS) ? HALF_DEPTH : MAX_ROWS;
   localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int RW = $clog2(ROWS + 1);
   localparam logic [RW:0] ROWS_L = (RW + 1)'(ROWS);

   // Sequencer state
   logic          wave_ff, wave_in;
   logic          piezo_ff, piezo_in;
   logic [1:0]    mode_ff, mode_in;
   logic [7:0]    hold_ff, hold_in;
   logic          act_ff, act_in;
   logic          pend_ff, pend_in;
   logic [RW-1:0] row_ff, row_in;
   logic [7:0]    half_ff, half_in;
   logic [7:0]    tog_ff, tog_in;
   logic [7:0]    rld_ff, rld_in;

   // Table storage and prefetch ([k][p]: k 0 count / 1 half-period, p 0 row / 1 row+1)
   logic          ent_vld_ff [2][ROWS];
   logic          hit_ff     [2][2];
   logic          vld_ff     [2][2];
   logic [7:0]    byp_ff     [2][2];
   logic [7:0]    ram_q      [2][2];
   logic [7:0]    val        [2][2];

   logic          acc;
   logic          wr_ok;
   logic [3:0]    wr_row4;
   logic [AW-1:0] wr_addr;
   logic          wr_half;
   logic [RW:0]   row_a, row_b;
   logic          in_a, in_b;
   logic [RW-1:0] row_nx;
   logic [RW:0]   rownx_b;
   logic [AW-1:0] addr_a, addr_b;
   logic          nx_in_a, nx_in_b;
   logic          ld2;
   logic [7:0]    ld2_cnt, ld2_half;
   logic          ld2_in;

   // Output register plus skid stage
   logic          out_v_ff, skid_v_ff;
   rsp_type       out_ff, skid_ff;
   rsp_type       res;
   logic          pop;

   assign acc       = req_valid && !req_stall;
   assign req_stall = skid_v_ff;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;
   assign pop       = out_v_ff && !rsp_stall;

   assign wr_row4 = {1'b0, req_data.entry_index[3:1]};
   assign wr_addr = req_data.entry_index[AW:1];
   assign wr_half = req_data.entry_index[0];
   assign wr_ok   = acc && (req_data.cmd == CMD_WRITE) && (wr_row4 < 4'(ROWS));

   // Current rows and their table bytes
   assign row_a = {1'b0, row_ff};
   assign row_b = row_a + (RW + 1)'(1);
   assign in_a  = row_a < ROWS_L;
   assign in_b  = row_b < ROWS_L;

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         for (int p = 0; p < 2; p++) begin
            if (hit_ff[k][p]) begin
               val[k][p] = byp_ff[k][p];
            end else if (vld_ff[k][p]) begin
               val[k][p] = ram_q[k][p];
            end else begin
               val[k][p] = tune_default((p == 0) ? 3'(row_a) : 3'(row_b), 1'(k));
            end
         end
      end
   end

   // Prefetch addresses follow the next row
   assign row_nx  = reset ? '0 : row_in;
   assign rownx_b = {1'b0, row_nx} + (RW + 1)'(1);
   assign addr_a  = row_nx[AW-1:0];
   assign addr_b  = rownx_b[AW-1:0];
   assign nx_in_a = {1'b0, row_nx} < ROWS_L;
   assign nx_in_b = rownx_b < ROWS_L;

   for (genvar g = 0; g < 2; g++) begin : g_ram
      ttsmb_ram #(
         .WIDTH (8),
         .DEPTH (ROWS)
      ) u_ram (
         .clock    (clock),
         .wr_en    (wr_ok && (wr_half == 1'(g))),
         .wr_addr  (wr_addr),
         .wr_data  (req_data.entry_value),
         .rd0_addr (addr_a),
         .rd0_data (ram_q[g][0]),
         .rd1_addr (addr_b),
         .rd1_data (ram_q[g][1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 2; k++) begin
            for (int r = 0; r < ROWS; r++) begin
               ent_vld_ff[k][r] <= 1'b0;
            end
            for (int p = 0; p < 2; p++) begin
               hit_ff[k][p] <= 1'b0;
               vld_ff[k][p] <= 1'b0;
            end
         end
      end else begin
         for (int k = 0; k < 2; k++) begin
            if (wr_ok && (wr_half == 1'(k))) begin
               ent_vld_ff[k][wr_addr] <= 1'b1;
            end
            vld_ff[k][0] <= nx_in_a && ent_vld_ff[k][addr_a];
            vld_ff[k][1] <= nx_in_b && ent_vld_ff[k][addr_b];
            // A write in this cycle is not yet in the RAM read data
            hit_ff[k][0] <= wr_ok && (wr_half == 1'(k)) && (wr_addr == addr_a);
            hit_ff[k][1] <= wr_ok && (wr_half == 1'(k)) && (wr_addr == addr_b);
         end
      end
      for (int k = 0; k < 2; k++) begin
         for (int p = 0; p < 2; p++) begin
            byp_ff[k][p] <= req_data.entry_value;
         end
      end
   end

   // Second load of a tick reads the row after a pending start's first row
   assign ld2_cnt  = pend_ff ? val[0][1] : val[0][0];
   assign ld2_half = pend_ff ? val[1][1] : val[1][0];
   assign ld2_in   = pend_ff ? in_b : in_a;

   always_comb begin
      wave_in  = wave_ff;
      piezo_in = piezo_ff;
      mode_in  = mode_ff;
      hold_in  = hold_ff;
      act_in   = act_ff;
      pend_in  = pend_ff;
      row_in   = row_ff;
      half_in  = half_ff;
      tog_in   = tog_ff;
      rld_in   = rld_ff;
      ld2      = 1'b0;
      if (acc) begin
         case (req_data.cmd)
            CMD_TICK: begin
               wave_in = !wave_ff;
               if (req_data.button) begin
                  if (hold_ff != 8'hFF) begin
                     hold_in = hold_ff + 8'd1;
                  end
               end else if (hold_ff != 8'd0) begin
                  mode_in = mode_ff + 2'd1;
                  hold_in = 8'd0;
               end
               if (pend_ff) begin
                  pend_in = 1'b0;
                  if (!in_a || (val[0][0] == 8'd0)) begin
                     act_in = 1'b0;
                  end else begin
                     tog_in  = val[0][0];
                     half_in = val[1][0];
                     rld_in  = val[1][0];
                     row_in  = row_ff + RW'(1);
                  end
               end
               if (act_in) begin
                  if (half_in != 8'd0) begin
                     half_in = half_in - 8'd1;
                     if (half_in == 8'd0) begin
                        piezo_in = !piezo_ff;
                        if (tog_in != 8'd0) begin
                           tog_in = tog_in - 8'd1;
                        end
                        if (tog_in == 8'd0) begin
                           ld2 = 1'b1;
                        end else begin
                           half_in = rld_in;
                        end
                     end
                  end else begin
                     // rest
                     if (tog_in != 8'd0) begin
                        tog_in = tog_in - 8'd1;
                     end
                     if (tog_in == 8'd0) begin
                        ld2 = 1'b1;
                     end
                  end
                  if (ld2) begin
                     if (!ld2_in || (ld2_cnt == 8'd0)) begin
                        act_in = 1'b0;
                     end else begin
                        tog_in  = ld2_cnt;
                        half_in = ld2_half;
                        rld_in  = ld2_half;
                        row_in  = row_in + RW'(1);
                     end
                  end
               end
            end
            CMD_START: begin
               act_in  = 1'b1;
               pend_in = 1'b1;
               row_in  = '0;
            end
            CMD_STOP: begin
               act_in  = 1'b0;
               pend_in = 1'b0;
            end
            CMD_WRITE: begin
               // Keep the reload value in step with the current pair's half-period byte
               if (wr_ok && wr_half && (row_ff != '0) &&
                   (4'(row_ff) == wr_row4 + 4'd1)) begin
                  rld_in = req_data.entry_value;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff  <= 1'b0;
         piezo_ff <= 1'b0;
         mode_ff  <= 2'd0;
         hold_ff  <= 8'd0;
         act_ff   <= 1'b0;
         pend_ff  <= 1'b0;
         row_ff   <= '0;
         half_ff  <= 8'd0;
         tog_ff   <= 8'd0;
         rld_ff   <= 8'd0;
      end else begin
         wave_ff  <= wave_in;
         piezo_ff <= piezo_in;
         mode_ff  <= mode_in;
         hold_ff  <= hold_in;
         act_ff   <= act_in;
         pend_ff  <= pend_in;
         row_ff   <= row_in;
         half_ff  <= half_in;
         tog_ff   <= tog_in;
         rld_ff   <= rld_in;
      end
   end

   assign res.tone_level = piezo_in;
   assign res.tick_wave  = wave_in;
   assign res.mode       = mode_in;
   assign res.playing    = act_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (pop || !out_v_ff) begin
            if (skid_v_ff) begin
               out_v_ff  <= 1'b1;
               skid_v_ff <= 1'b0;
            end else begin
               out_v_ff <= acc;
            end
         end else if (acc) begin
            skid_v_ff <= 1'b1;
         end
      end
      if (pop || !out_v_ff) begin
         out_ff <= skid_v_ff ? skid_ff : res;
      end else if (acc) begin
         skid_ff <= res;
      end
   end

   `TTSMB_ASSERT_IMP(a_skid_behind_out, clock, reset, skid_v_ff, out_v_ff,
      "skid stage holds a transaction while the output register is empty")
   `TTSMB_ASSERT_IMP(a_pend_active, clock, reset, pend_ff, act_ff && (row_ff == '0),
      "start pending without playback at the first row")
   `TTSMB_ASSERT_IMP(a_row_range, clock, reset, act_ff, ({1'b0, row_ff} <= ROWS_L),
      "row pointer past the end of the tune")
   `TTSMB_ASSERT_NXT(a_tick_wave, clock, reset, acc && (req_data.cmd == CMD_TICK),
      wave_ff != $past(wave_ff), "tick did not invert the square wave")

endmodule

`default_nettype wire

/* sim/tick_tone_sequencer_with_mode_button_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick tone sequencer testbench
// Drives tick, start, stop and table write transactions through the request
// channel and checks every response against a cycle-free model of the player,
// with random gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------

module tick_tone_sequencer_with_mode_button_test;
   import ttsmb_pkg::*;

   localparam int TUNE_DEPTH = 16;
   localparam int IDLE_LIMIT = 2000;
   localparam int MAX_SHOWN  = 10;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // player model state
   logic [7:0]  tune_mem [TUNE_DEPTH];
   int unsigned note_ptr;
   logic [7:0]  half_left;
   logic [7:0]  toggles_left;
   logic [7:0]  hold_count;
   logic        piezo_lvl;
   logic        wave_lvl;
   logic [1:0]  mode_sel;

   rsp_type tone_expect_q [$];
   int      fault_count = 0;
   int      sent_count  = 0;
   int      idle_cycles = 0;
   int      stall_run   = 0;
   bit      quiet       = 1'b0;

   tick_tone_sequencer_with_mode_button #(
      .TABLE_DEPTH(TUNE_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------------
   // Player model
   // ------------------------------------------------------------------------
   function automatic void reset_player();
      for (int i = 0; i < TUNE_DEPTH; i++) begin
         tune_mem[i] = TUNE_DEFAULT[i];
      end
      note_ptr     = 0;
      half_left    = '0;
      toggles_left = '0;
      hold_count   = '0;
      piezo_lvl    = 1'b0;
      wave_lvl     = 1'b0;
      mode_sel     = '0;
   endfunction

   function automatic logic [7:0] tune_byte(input int unsigned idx);
      return (idx < TUNE_DEPTH) ? tune_mem[idx] : 8'd0;
   endfunction

   // Load the (count, half-period) pair at note_ptr-1 and note_ptr, or go idle
   function automatic void fetch_note();
      int unsigned p;
      p = note_ptr;
      if (p == 0 || p >= TUNE_DEPTH || tune_byte(p - 1) == 8'd0) begin
         note_ptr = 0;
         return;
      end
      toggles_left = tune_byte(p - 1);
      half_left    = tune_byte(p);
      note_ptr     = p + 2;
   endfunction

   function automatic void apply_tick(input logic pressed);
      wave_lvl = ~wave_lvl;
      if (pressed) begin
         if (hold_count != 8'hFF) hold_count = hold_count + 8'd1;
      end else if (hold_count != 8'd0) begin
         mode_sel   = mode_sel + 2'd1;
         hold_count = '0;
      end
      if (note_ptr == 1) fetch_note();
      if (note_ptr == 0) return;
      if (half_left != 8'd0) begin
         half_left = half_left - 8'd1;
         if (half_left == 8'd0) begin
            piezo_lvl = ~piezo_lvl;
            if (toggles_left != 8'd0) toggles_left = toggles_left - 8'd1;
            if (toggles_left == 8'd0) begin
               fetch_note();
            end else begin
               half_left = (note_ptr >= 2) ? tune_byte(note_ptr - 2) : 8'd0;
            end
         end
      end else begin
         // rest: count runs down in ticks, next pair on the same tick
         if (toggles_left != 8'd0) toggles_left = toggles_left - 8'd1;
         if (toggles_left == 8'd0) fetch_note();
      end
   endfunction

   function automatic rsp_type predict_tone(input req_type item);
      rsp_type r;
      case (item.cmd)
         CMD_TICK:  apply_tick(item.button);
         CMD_START: note_ptr = 1;
         CMD_STOP:  note_ptr = 0;
         default:   tune_mem[item.entry_index] = item.entry_value;
      endcase
      r.tone_level = piezo_lvl;
      r.tick_wave  = wave_lvl;
      r.mode       = mode_sel;
      r.playing    = (note_ptr != 0);
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic int pick_gap();
      int roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic req_type make_req(input cmd_type cmd, input logic button,
                                        input logic [3:0] idx, input logic [7:0] val);
      req_type r;
      r.cmd         = cmd;
      r.button      = button;
      r.entry_index = idx;
      r.entry_value = val;
      return r;
   endfunction

   function automatic req_type noisy_req(input cmd_type cmd, input logic button);
      return make_req(cmd, button, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
   endfunction

   function automatic logic [7:0] pick_count();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(1, 4));
   endfunction

   function automatic logic [7:0] pick_half();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) return 8'd0;
      if (roll < 33) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(1, 3));
   endfunction

   task automatic send_req(input req_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      tone_expect_q.push_back(predict_tone(item));
      sent_count++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (tone_expect_q.size() != 0);
   endtask

   // Program rows 0..rows-1 with random pairs
   task automatic load_tune(input int rows);
      for (int r = 0; r < rows; r++) begin
         send_req(make_req(CMD_WRITE, 1'($urandom_range(0, 1)), 4'(2 * r), pick_count()));
         send_req(make_req(CMD_WRITE, 1'($urandom_range(0, 1)), 4'(2 * r + 1), pick_half()));
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_directed();
      // note of two toggles, a two tick rest, then a zero count
      send_req(make_req(CMD_WRITE, 1'b1, 4'd0, 8'd2));
      send_req(make_req(CMD_WRITE, 1'b0, 4'd1, 8'd1));
      send_req(make_req(CMD_WRITE, 1'b1, 4'd2, 8'd2));
      send_req(make_req(CMD_WRITE, 1'b0, 4'd3, 8'd0));
      send_req(make_req(CMD_WRITE, 1'b0, 4'd4, 8'd0));
      send_req(make_req(CMD_START, 1'b1, 4'd9, 8'h5A));
      send_req(make_req(CMD_TICK, 1'b1, 4'd0, 8'd0));
      send_req(make_req(CMD_TICK, 1'b1, 4'd0, 8'd0));
      send_req(make_req(CMD_TICK, 1'b0, 4'd0, 8'd0));
      send_req(make_req(CMD_TICK, 1'b0, 4'd0, 8'd0));
      send_req(make_req(CMD_TICK, 1'b0, 4'd0, 8'd0));
      send_req(make_req(CMD_TICK, 1'b0, 4'd0, 8'd0));
      // zero count on the very first pair
      send_req(make_req(CMD_WRITE, 1'b0, 4'd0, 8'd0));
      send_req(make_req(CMD_START, 1'b0, 4'd0, 8'd0));
      send_req(make_req(CMD_TICK, 1'b0, 4'd15, 8'hFF));
      // extreme values, long rest interrupted by stop
      send_req(make_req(CMD_WRITE, 1'b1, 4'd15, 8'hFF));
      send_req(make_req(CMD_WRITE, 1'b0, 4'd0, 8'hFF));
      send_req(make_req(CMD_WRITE, 1'b1, 4'd1, 8'h00));
      send_req(make_req(CMD_START, 1'b0, 4'd15, 8'hFF));
      send_req(make_req(CMD_TICK, 1'b1, 4'd15, 8'hFF));
      send_req(make_req(CMD_STOP, 1'b1, 4'd15, 8'hFF));
      send_req(make_req(CMD_TICK, 1'b1, 4'd0, 8'd0));
      send_req(make_req(CMD_TICK, 1'b0, 4'd0, 8'd0));
   endtask

   task automatic test_table_end();
      // every row filled with a nonzero count so playback runs off the end
      quiet = 1'b1;
      for (int i = 0; i < TUNE_DEPTH; i += 2) begin
         send_req(make_req(CMD_WRITE, 1'b0, 4'(i), 8'($urandom_range(1, 2))));
         send_req(make_req(CMD_WRITE, 1'b1, 4'(i + 1), 8'($urandom_range(0, 1))));
      end
      send_req(noisy_req(CMD_START, 1'b0));
      repeat (20) send_req(noisy_req(CMD_TICK, 1'($urandom_range(0, 1))));
      quiet = 1'b0;
      wait_drained();
   endtask

   task automatic test_hold_saturation();
      // hold the button past 255 ticks after a tune is started
      load_tune(4);
      send_req(noisy_req(CMD_START, 1'b1));
      repeat (260) send_req(noisy_req(CMD_TICK, 1'b1));
      repeat (3) send_req(noisy_req(CMD_TICK, 1'b0));
   endtask

   task automatic test_random_tunes();
      int  stop_at;
      int  rows;
      int  roll;
      logic btn;
      stop_at = sent_count + 100;
      btn     = 1'b0;
      while (sent_count < stop_at) begin
         rows = $urandom_range(1, 8);
         load_tune(rows);
         if (rows < 8 && $urandom_range(0, 1) == 1) begin
            send_req(make_req(CMD_WRITE, btn, 4'(2 * rows), 8'd0));
         end
         if ($urandom_range(0, 9) != 0) send_req(noisy_req(CMD_START, btn));
         repeat ($urandom_range(8, 40)) begin
            if ($urandom_range(0, 4) == 0) btn = ~btn;
            roll = $urandom_range(0, 99);
            if (roll < 4) send_req(noisy_req(CMD_STOP, btn));
            else if (roll < 8) send_req(noisy_req(CMD_START, btn));
            else if (roll < 12) send_req(noisy_req(CMD_WRITE, btn));
            else send_req(noisy_req(CMD_TICK, btn));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Response side: random stalls, checking, watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_run > 0) begin
         rsp_stall <= 1'b1;
         stall_run <= stall_run - 1;
      end else if (!quiet && $urandom_range(0, 99) < 20) begin
         rsp_stall <= 1'b1;
         stall_run <= pick_gap();
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tone_expect_q.size() == 0) begin
            fault_count++;
            if (fault_count <= MAX_SHOWN) begin
               $display("ERROR: unexpected response tone=%0b wave=%0b mode=%0d playing=%0b",
                        rsp_data.tone_level, rsp_data.tick_wave, rsp_data.mode,
                        rsp_data.playing);
            end
         end else begin
            want = tone_expect_q.pop_front();
            if (rsp_data.tone_level !== want.tone_level ||
                rsp_data.tick_wave  !== want.tick_wave  ||
                rsp_data.mode       !== want.mode       ||
                rsp_data.playing    !== want.playing) begin
               fault_count++;
               if (fault_count <= MAX_SHOWN) begin
                  $display({"ERROR: transaction mismatch expected tone=%0b wave=%0b ",
                            "mode=%0d playing=%0b, got tone=%0b wave=%0b mode=%0d ",
                            "playing=%0b"},
                           want.tone_level, want.tick_wave, want.mode, want.playing,
                           rsp_data.tone_level, rsp_data.tick_wave, rsp_data.mode,
                           rsp_data.playing);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset_player();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_table_end();
      test_hold_saturation();
      test_random_tunes();
      wait_drained();
      repeat (10) @(posedge clock);
      if (fault_count == 0 && tone_expect_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
